// ===== rtl/csis_pkg.sv =====
// Package for the case-insensitive substring search block.
// Holds sizes, register indexes, shared types and byte helper functions.
// Depends on nothing; every other file refers to it by scoped names.
package csis_pkg;

   localparam int NEEDLE_MAX = 16;
   localparam int LEN_W      = $clog2(NEEDLE_MAX + 1);
   localparam int IDX_W      = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
   localparam int CFG_LEN_W  = 5;
   localparam int CMP_W      = ((LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W) + 1;
   localparam int POS_W      = 16;
   localparam int BYTE_W     = 8;
   localparam int HALF_BYTES = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   localparam logic [POS_W-1:0]     POS_MAX   = {POS_W{1'b1}};
   localparam logic [BYTE_W-1:0]    TERMINATOR = 8'h00;

   localparam logic [CSR_IDX_W-1:0] REG_NEEDLE_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NEEDLE_LOW    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_NEEDLE_HIGH   = 2'd2;

   typedef logic [NEEDLE_MAX-1:0][BYTE_W-1:0] window_type;

   typedef struct packed {
      logic [LEN_W-1:0]      eff_len;
      logic [CSR_DATA_W-1:0] needle_low;
      logic [CSR_DATA_W-1:0] needle_high;
   } needle_cfg_type;

   // ASCII a-z folded to upper case; every other byte passes unchanged.
   function automatic logic [BYTE_W-1:0] fold_upper(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] r;
      r = b;
      if (b >= 8'h61 && b <= 8'h7a) begin
         r = b - 8'h20;
      end
      return r;
   endfunction

   // Needle byte k; bytes past the two configured words read as zero.
   function automatic logic [BYTE_W-1:0] needle_byte(input logic [CSR_DATA_W-1:0] low,
                                                     input logic [CSR_DATA_W-1:0] high,
                                                     input logic [IDX_W:0]        k);
      logic [BYTE_W-1:0] r;
      r = '0;
      if (k < (IDX_W+1)'(HALF_BYTES)) begin
         r = low[k[2:0]*BYTE_W +: BYTE_W];
      end else if (k < (IDX_W+1)'(2*HALF_BYTES)) begin
         r = high[k[2:0]*BYTE_W +: BYTE_W];
      end
      return r;
   endfunction

endpackage

// ===== rtl/case_insensitive_substring_search.sv =====
// Case-insensitive substring search, top level; uses csis_pkg, csis_csr, csis_matcher.
// A result passes the input register, then the output register, before it shows on rsp_valid;
// a result stalled in the output register holds the next byte in the input register.
// Throughput: one byte per cycle unless a stalled result holds the output register.
// Reset is synchronous and active high: it clears the window, the position, the needle
// registers and all valid flags, and leaves the search idle until a first-marked byte.
module case_insensitive_substring_search (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_text_byte,
   input  logic                            req_first_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_found,
   output logic [15:0]                     rsp_start_position,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [csis_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [csis_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int PW = csis_pkg::POS_W;
   localparam int NM = csis_pkg::NEEDLE_MAX;

   csis_pkg::needle_cfg_type cfg;

   csis_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Input stage: one accepted transaction waits here for the compare stage.
   logic       s1_valid_ff;
   logic [7:0] s1_text_ff;
   logic       s1_first_ff;
   logic       advance;
   logic       fire;
   logic       req_take;

   // The compare stage may run whenever the output register is free or drains now.
   assign advance   = !rsp_valid || !rsp_stall;
   assign fire      = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_text_ff  <= req_text_byte;
         s1_first_ff <= req_first_byte;
      end
   end

   // Search state: window of folded bytes (newest at the top slot), position, done flag.
   csis_pkg::window_type window_ff, window_in, window_cur, window_shift;
   logic [PW-1:0]        pos_ff, pos_in, pos_cur;
   logic                 done_ff, done_in, done_cur;
   logic                 bytes_equal;
   logic [PW:0]          pos_plus;
   logic                 has_result, result_found;
   logic [PW-1:0]        result_pos;

   // A first-marked byte restarts the search before it is looked at.
   assign window_cur   = s1_first_ff ? '0 : window_ff;
   assign pos_cur      = s1_first_ff ? '0 : pos_ff;
   assign done_cur     = s1_first_ff ? 1'b0 : done_ff;
   assign window_shift = {csis_pkg::fold_upper(s1_text_ff), window_cur[NM-1:1]};
   assign pos_plus     = {1'b0, pos_cur} + (PW+1)'(1);

   csis_matcher u_matcher (
      .window      (window_shift),
      .cfg         (cfg),
      .bytes_equal (bytes_equal)
   );

   always_comb begin
      window_in    = window_cur;
      pos_in       = pos_cur;
      done_in      = done_cur;
      has_result   = 1'b0;
      result_found = 1'b0;
      result_pos   = '0;
      if (!done_cur) begin
         if (cfg.eff_len == '0) begin
            // An empty needle matches at the start on the very first byte.
            done_in      = 1'b1;
            has_result   = 1'b1;
            result_found = 1'b1;
         end else begin
            window_in = window_shift;
            if (pos_plus >= (PW+1)'(cfg.eff_len) && bytes_equal) begin
               done_in      = 1'b1;
               has_result   = 1'b1;
               result_found = 1'b1;
               // Once the position has saturated the start is reported as saturated too.
               if (pos_cur == csis_pkg::POS_MAX) begin
                  result_pos = csis_pkg::POS_MAX;
               end else begin
                  result_pos = PW'(pos_plus - (PW+1)'(cfg.eff_len));
               end
            end else if (s1_text_ff == csis_pkg::TERMINATOR) begin
               done_in    = 1'b1;
               has_result = 1'b1;
            end else if (pos_cur != csis_pkg::POS_MAX) begin
               pos_in = PW'(pos_plus);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         pos_ff    <= '0;
         done_ff   <= 1'b1;
      end else if (fire) begin
         window_ff <= window_in;
         pos_ff    <= pos_in;
         done_ff   <= done_in;
      end
   end

   // Output register: holds one result transaction until the consumer takes it.
   logic        rsp_valid_ff;
   logic        rsp_found_ff;
   logic [15:0] rsp_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= has_result;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && has_result) begin
         rsp_found_ff <= result_found;
         rsp_pos_ff   <= result_pos;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_start_position = rsp_pos_ff;

endmodule

// ===== rtl/csis_csr.sv =====
// Configuration registers of the substring search: needle length and bytes.
// Uses csis_pkg for register indexes and the configuration struct.
module csis_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [csis_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [csis_pkg::CSR_DATA_W-1:0]   csr_data,
   output csis_pkg::needle_cfg_type          cfg
);

   logic [csis_pkg::CFG_LEN_W-1:0]  length_ff;
   logic [csis_pkg::CSR_DATA_W-1:0] low_ff;
   logic [csis_pkg::CSR_DATA_W-1:0] high_ff;
   logic [csis_pkg::CMP_W-1:0]      length_wide;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         low_ff    <= '0;
         high_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            csis_pkg::REG_NEEDLE_LENGTH: length_ff <= csr_data[csis_pkg::CFG_LEN_W-1:0];
            csis_pkg::REG_NEEDLE_LOW:    low_ff    <= csr_data;
            csis_pkg::REG_NEEDLE_HIGH:   high_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Lengths beyond the window depth are used as the full depth.
   assign length_wide = csis_pkg::CMP_W'(length_ff);

   always_comb begin
      cfg.needle_low  = low_ff;
      cfg.needle_high = high_ff;
      if (length_wide > csis_pkg::CMP_W'(csis_pkg::NEEDLE_MAX)) begin
         cfg.eff_len = csis_pkg::LEN_W'(csis_pkg::NEEDLE_MAX);
      end else begin
         cfg.eff_len = csis_pkg::LEN_W'(length_wide);
      end
   end

endmodule

// ===== rtl/csis_matcher.sv =====
// Parallel compare of the newest window bytes against the folded needle.
// Uses csis_pkg for the window type and the byte helper functions.
module csis_matcher (
   input  csis_pkg::window_type     window,
   input  csis_pkg::needle_cfg_type cfg,
   output logic                     bytes_equal
);

   logic [csis_pkg::LEN_W:0] first_slot;

   assign first_slot = (csis_pkg::LEN_W+1)'(csis_pkg::NEEDLE_MAX)
                     - (csis_pkg::LEN_W+1)'(cfg.eff_len);

   // Slot j holds needle byte j - first_slot when it lies in the active tail.
   always_comb begin
      logic [csis_pkg::LEN_W:0] k_wide;
      logic [csis_pkg::BYTE_W-1:0] want;
      bytes_equal = 1'b1;
      for (int j = 0; j < csis_pkg::NEEDLE_MAX; j++) begin
         k_wide = (csis_pkg::LEN_W+1)'(j) - first_slot;
         want   = csis_pkg::fold_upper(csis_pkg::needle_byte(
                     cfg.needle_low, cfg.needle_high,
                     k_wide[csis_pkg::IDX_W:0]));
         if ((csis_pkg::LEN_W+1)'(j) >= first_slot && window[j] != want) begin
            bytes_equal = 1'b0;
         end
      end
   end

endmodule

// ===== rtl/csis_checker.sv =====
// Port-level checks for the substring search top level, with its bind.
// Uses csis_pkg for the configuration port widths.
module csis_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic [7:0]                      req_text_byte,
   input logic                            req_first_byte,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic                            rsp_found,
   input logic [15:0]                     rsp_start_position,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [csis_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [csis_pkg::CSR_DATA_W-1:0] csr_data
);

   // A stalled result transaction stays offered with the same payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found)
                                 && $stable(rsp_start_position))
      else $error("result changed while stalled");

   // A not-found result always carries position zero.
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_start_position == 16'd0)
      else $error("not-found result with nonzero position");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // The input side only backs up when a result is waiting and stalled.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a blocked result");

endmodule

bind case_insensitive_substring_search csis_checker u_csis_checker (.*);
